@@ hw/rtl/pidst_pkg.sv @@
// package: shared types, constants and the square root step for the point-in-crystal test
package pidst_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SQ_IN_W = 46;
    localparam int ROOT_W = 23;
    localparam int REM_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TSTART  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TSLOPE  = 3'd6;

    typedef struct packed {
        logic [14:0] length;
        logic [14:0] radius;
        logic [14:0] round;
        logic [31:0] contact;
        logic [31:0] hole;
        logic [14:0] tstart;
        logic [15:0] tslope;
    } pidst_cfg_t;

    typedef struct packed {
        logic        valid;
        logic        ok;
        logic        tap_en;
        logic        edge_en;
        logic [30:0] tprod;
    } pidst_side_t;

    typedef struct packed {
        logic [SQ_IN_W-1:0] v;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } pidst_root_t;

    function automatic pidst_root_t sqrt_step(input pidst_root_t a);
        pidst_root_t      r;
        logic [REM_W+1:0] rn;
        logic [REM_W+1:0] t;
        rn = {a.rem, a.v[SQ_IN_W-1 -: 2]};
        t = {2'b00, a.root, 2'b01};
        r.v = {a.v[SQ_IN_W-3:0], 2'b00};
        if (rn >= t)
        begin
            rn = rn - t;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        r.rem = rn[REM_W-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/pidst_front.sv @@
// front stages: bounds, squares, radius and exclusion tests, square root operands
module pidst_front #(
    parameter int COORD_WIDTH = pidst_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  pidst_pkg::pidst_cfg_t  cfg,
    input  logic                   in_valid,
    input  logic [COORD_WIDTH-1:0] x,
    input  logic [COORD_WIDTH-1:0] y,
    input  logic [COORD_WIDTH-1:0] z,
    output pidst_pkg::pidst_side_t side,
    output pidst_pkg::pidst_root_t root_s,
    output pidst_pkg::pidst_root_t root_d
);
    import pidst_pkg::*;

    localparam int AW = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;
    localparam int ZW = AW + 1;

    logic [COORD_WIDTH-1:0] ax, ay;
    logic [AW-1:0] ax_e, ay_e;
    logic signed [ZW-1:0] zs, zl_e, zmb, tz_e, cl_e, zmh, dz_t, dz_e;
    logic big;

    logic        b_valid_reg, b_ok_reg, b_tap_reg, b_edge_reg, b_cz_reg, b_hz_reg;
    logic [31:0] b_sx_reg, b_sy_reg;
    logic [29:0] b_dsq_reg;
    logic [14:0] b_tz_reg;

    logic [32:0] s33;
    logic [31:0] mr_sq, cr_sq, hr_sq;
    logic [29:0] br_sq;
    logic signed [31:0] dd;
    logic [29:0] ddp;
    logic c_ok;

    logic        c_valid_reg;
    pidst_side_t side_reg;
    pidst_root_t rs_reg, rd_reg;

    always_comb
    begin
        ax = x[COORD_WIDTH-1] ? (~x + 1'b1) : x;
        ay = y[COORD_WIDTH-1] ? (~y + 1'b1) : y;
        ax_e = AW'(ax);
        ay_e = AW'(ay);
        big = (ax_e > AW'(65535)) || (ay_e > AW'(65535));
        zs = {{(ZW-COORD_WIDTH){z[COORD_WIDTH-1]}}, z};
        zl_e = $signed(ZW'(cfg.length));
        tz_e = $signed(ZW'(cfg.tstart));
        cl_e = $signed(ZW'(cfg.contact[15:0]));
        zmb = zl_e - $signed(ZW'(cfg.round));
        zmh = zl_e - $signed(ZW'(cfg.hole[15:0]));
        dz_t = zs - tz_e;
        dz_e = zs - zmb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ok_reg   <= !big && !zs[ZW-1] && (zs < zl_e);
            b_tap_reg  <= zs > tz_e;
            b_edge_reg <= zs > zmb;
            b_cz_reg   <= zs <= cl_e;
            b_hz_reg   <= zs >= zmh;
            b_sx_reg   <= 32'(ax_e[15:0]) * 32'(ax_e[15:0]);
            b_sy_reg   <= 32'(ay_e[15:0]) * 32'(ay_e[15:0]);
            b_dsq_reg  <= 30'(dz_e[14:0]) * 30'(dz_e[14:0]);
            b_tz_reg   <= dz_t[14:0];
        end
    end

    always_comb
    begin
        s33 = 33'(b_sx_reg) + 33'(b_sy_reg);
        mr_sq = 32'(cfg.radius) * 32'(cfg.radius);
        cr_sq = 32'(cfg.contact[31:16]) * 32'(cfg.contact[31:16]);
        hr_sq = 32'(cfg.hole[31:16]) * 32'(cfg.hole[31:16]);
        br_sq = 30'(cfg.round) * 30'(cfg.round);
        dd = $signed({2'b00, br_sq}) - $signed({2'b00, b_dsq_reg});
        ddp = (dd[31] || dd == 32'sd0) ? 30'd0 : dd[29:0];
        c_ok = b_ok_reg && (s33 <= 33'(mr_sq))
            && !((cfg.contact[31:16] != 16'd0) && b_cz_reg && (s33 <= 33'(cr_sq)))
            && !((cfg.hole[31:16] != 16'd0) && b_hz_reg && (s33 <= 33'(hr_sq)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg.valid   <= b_valid_reg;
            side_reg.ok      <= c_ok;
            side_reg.tap_en  <= b_tap_reg;
            side_reg.edge_en <= b_edge_reg;
            side_reg.tprod   <= 31'(cfg.tslope) * 31'(b_tz_reg);
            rs_reg.v    <= {s33[29:0], 16'd0};
            rs_reg.rem  <= '0;
            rs_reg.root <= '0;
            rd_reg.v    <= {ddp, 16'd0};
            rd_reg.rem  <= '0;
            rd_reg.root <= '0;
        end
    end

    always_comb
    begin
        side = side_reg;
        side.valid = c_valid_reg;
    end

    assign root_s = rs_reg;
    assign root_d = rd_reg;

endmodule

@@ hw/rtl/pidst_cell.sv @@
// square root cell: one result bit of both roots per stage, sideband carried along
module pidst_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  pidst_pkg::pidst_side_t side_in,
    input  pidst_pkg::pidst_root_t rs_in,
    input  pidst_pkg::pidst_root_t rd_in,
    output pidst_pkg::pidst_side_t side_out,
    output pidst_pkg::pidst_root_t rs_out,
    output pidst_pkg::pidst_root_t rd_out
);
    import pidst_pkg::*;

    logic        valid_reg;
    pidst_side_t side_reg;
    pidst_root_t rs_reg, rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= side_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            rs_reg   <= sqrt_step(rs_in);
            rd_reg   <= sqrt_step(rd_in);
        end
    end

    always_comb
    begin
        side_out = side_reg;
        side_out.valid = valid_reg;
    end

    assign rs_out = rs_reg;
    assign rd_out = rd_reg;

endmodule

@@ hw/rtl/point_in_detector_solid_test_core.sv @@
// top level: configuration registers, front stages, square root cell chain, final compare
// stages: input register, two front stages, 23 root cells, output register;
// throughput one item per cycle while the output is not stalled
// the whole pipeline holds while a result waits at the output
// reset clears valid flags and loads register defaults (taper start 32767)
module point_in_detector_solid_test_core #(
    parameter int COORD_WIDTH = pidst_pkg::COORD_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [pidst_pkg::CFG_IDX_W-1:0]             cfg_idx,
    input  logic [pidst_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // inside_res
    output logic [7:0]                                  m_tdata
);
    import pidst_pkg::*;

    pidst_cfg_t cfg_reg;
    logic en;
    logic in_valid_reg;
    logic [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic m_valid_reg, m_res_reg;
    logic [31:0] tap_lhs;
    logic signed [15:0] mrb;
    logic signed [26:0] edge_rhs, edge_lhs;
    logic fin_ok;

    pidst_side_t side_c [0:ROOT_W];
    pidst_root_t rs_c [0:ROOT_W];
    pidst_root_t rd_c [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length  <= '0;
            cfg_reg.radius  <= '0;
            cfg_reg.round   <= '0;
            cfg_reg.contact <= '0;
            cfg_reg.hole    <= '0;
            cfg_reg.tstart  <= 15'd32767;
            cfg_reg.tslope  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_LENGTH:  cfg_reg.length  <= cfg_data[14:0];
                REG_RADIUS:  cfg_reg.radius  <= cfg_data[14:0];
                REG_ROUND:   cfg_reg.round   <= cfg_data[14:0];
                REG_CONTACT: cfg_reg.contact <= cfg_data;
                REG_HOLE:    cfg_reg.hole    <= cfg_data;
                REG_TSTART:  cfg_reg.tstart  <= cfg_data[14:0];
                REG_TSLOPE:  cfg_reg.tslope  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign en = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= s_tdata[COORD_WIDTH-1:0];
            y_reg <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            z_reg <= s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
        end
    end

    pidst_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .cfg(cfg_reg),
        .in_valid(in_valid_reg),
        .x(x_reg),
        .y(y_reg),
        .z(z_reg),
        .side(side_c[0]),
        .root_s(rs_c[0]),
        .root_d(rd_c[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        pidst_cell u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .en(en),
            .side_in(side_c[i]),
            .rs_in(rs_c[i]),
            .rd_in(rd_c[i]),
            .side_out(side_c[i+1]),
            .rs_out(rs_c[i+1]),
            .rd_out(rd_c[i+1])
        );
    end

    always_comb
    begin
        tap_lhs = {3'b000, rs_c[ROOT_W].root, 6'd0} + {1'b0, side_c[ROOT_W].tprod};
        mrb = $signed({1'b0, cfg_reg.radius}) - $signed({1'b0, cfg_reg.round});
        edge_rhs = $signed({{3{mrb[15]}}, mrb, 8'd0}) + $signed({4'd0, rd_c[ROOT_W].root});
        edge_lhs = $signed({4'd0, rs_c[ROOT_W].root});
        fin_ok = side_c[ROOT_W].ok
            && !(side_c[ROOT_W].tap_en && (tap_lhs > {3'b000, cfg_reg.radius, 14'd0}))
            && !(side_c[ROOT_W].edge_en && (edge_lhs > edge_rhs));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= side_c[ROOT_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_res_reg <= fin_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, m_res_reg};

endmodule
